// File: sv/bmhpq_pkg.sv
// Shared types and codes for the binary max-heap priority queue.
package bmhpq_pkg;

    localparam int ACTION_W = 2;
    localparam int STATUS_W = 2;
    localparam int OUT_USER_W = STATUS_W + 1;

    localparam logic [ACTION_W-1:0] ACT_PUSH  = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_POP   = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_QUERY = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PUSH_RD,
        S_PUSH_CMP,
        S_POP_RD,
        S_POP_CAP,
        S_DN_RDL,
        S_DN_RDR,
        S_DN_SEL,
        S_DN_DEC,
        S_FIN_RD,
        S_FIN_CAP,
        S_OUT
    } state_t;

endpackage

// File: sv/bmhpq_mem.sv
// Single-port heap entry store with registered read data.
module bmhpq_mem #(
    parameter int AW = 6,
    parameter int W  = 48
) (
    input  logic          clk,
    input  logic          en,
    input  logic          we,
    input  logic [AW-1:0] addr,
    input  logic [W-1:0]  wdata,
    output logic [W-1:0]  rdata
);

    logic [W-1:0] ram [2**AW];
    logic [W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                ram[addr] <= wdata;
            end
            else
            begin
                rdata_reg <= ram[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: sv/bmhpq_cmp.sv
// Shared priority comparator used by both sift directions.
module bmhpq_cmp #(
    parameter int W = 16
) (
    input  logic [W-1:0] a,
    input  logic [W-1:0] b,
    output logic         lt
);

    assign lt = (a < b);

endmodule

// File: sv/binary_max_heap_priority_queue_unit.sv
// Top level of the binary max-heap priority queue with its sift sequencer.
//
// Requests arrive on the s_axis channel: tuser carries the action (push, pop,
// query), tdata the payload and its priority. Every request yields exactly one
// result on m_axis: the root entry after the request, the entry count and, in
// tuser, the empty flag and a status code.
// One request is worked at a time; s_axis_tready is high only while idle.
// A sequencer walks the heap through one single-port store and one shared
// comparator. A push climbs one level per parent read and compare, a pop
// descends one level per left read, right read, child select and decision,
// and both add steps to accept, place the entry, read the root and output.
// The result stays on m_axis until taken, and no new request is accepted
// before that, so a stalled receiver stalls the input.
// Reset empties the queue at once; the store is not cleared, since only
// entries below the count are ever read.
module binary_max_heap_priority_queue_unit #(
    parameter int DEPTH          = 64,
    parameter int DATA_WIDTH     = 32,
    parameter int PRIORITY_WIDTH = 16
) (
    input  logic clk,
    input  logic rst_n,
    input  logic s_axis_tvalid,
    output logic s_axis_tready,
    // data_value, priority_req, zero pad
    input  logic [((DATA_WIDTH+PRIORITY_WIDTH+7)/8)*8-1:0] s_axis_tdata,
    // action
    input  logic [bmhpq_pkg::ACTION_W-1:0] s_axis_tuser,
    output logic m_axis_tvalid,
    input  logic m_axis_tready,
    // front_value, front_priority, count, zero pad
    output logic [((DATA_WIDTH+PRIORITY_WIDTH+$clog2(DEPTH+1)+7)/8)*8-1:0] m_axis_tdata,
    // is_empty, status
    output logic [bmhpq_pkg::OUT_USER_W-1:0] m_axis_tuser
);

    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int XW    = AW + 2;
    localparam int EW    = DATA_WIDTH + PRIORITY_WIDTH;
    localparam int OBITS = EW + CW;
    localparam int OW    = ((OBITS + 7) / 8) * 8;

    bmhpq_pkg::state_t state_reg, state_next;
    logic [CW-1:0]                   count_reg, count_next;
    logic [AW-1:0]                   pos_reg, pos_next;
    logic [AW-1:0]                   big_idx_reg, big_idx_next;
    logic [DATA_WIDTH-1:0]           item_val_reg, item_val_next;
    logic [PRIORITY_WIDTH-1:0]       item_pri_reg, item_pri_next;
    logic [DATA_WIDTH-1:0]           big_val_reg, big_val_next;
    logic [PRIORITY_WIDTH-1:0]       big_pri_reg, big_pri_next;
    logic [DATA_WIDTH-1:0]           res_val_reg, res_val_next;
    logic [PRIORITY_WIDTH-1:0]       res_pri_reg, res_pri_next;
    logic [bmhpq_pkg::STATUS_W-1:0]  status_reg, status_next;

    logic                      mem_en, mem_we;
    logic [AW-1:0]             mem_addr;
    logic [EW-1:0]             mem_wdata, mem_rdata;
    logic [DATA_WIDTH-1:0]     rd_val;
    logic [PRIORITY_WIDTH-1:0] rd_pri;
    logic [PRIORITY_WIDTH-1:0] cmp_a, cmp_b;
    logic                      cmp_lt;

    logic [XW-1:0] left_x, right_x, count_x;
    logic [AW-1:0] parent;
    logic [CW-1:0] last;
    logic          req_fire, full;

    bmhpq_mem #(.AW(AW), .W(EW)) u_mem (
        .clk   (clk),
        .en    (mem_en),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    bmhpq_cmp #(.W(PRIORITY_WIDTH)) u_cmp (
        .a  (cmp_a),
        .b  (cmp_b),
        .lt (cmp_lt)
    );

    assign rd_val   = mem_rdata[DATA_WIDTH-1:0];
    assign rd_pri   = mem_rdata[EW-1:DATA_WIDTH];
    assign left_x   = {1'b0, pos_reg, 1'b1};
    assign right_x  = left_x + XW'(1);
    assign count_x  = XW'(count_reg);
    assign parent   = (pos_reg - AW'(1)) >> 1;
    assign last     = count_reg - CW'(1);
    assign full     = (count_reg == CW'(DEPTH));
    assign req_fire = s_axis_tvalid && s_axis_tready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            bmhpq_pkg::S_IDLE:
            begin
                if (req_fire)
                begin
                    case (s_axis_tuser)
                        bmhpq_pkg::ACT_PUSH:
                            state_next = full ? bmhpq_pkg::S_FIN_RD : bmhpq_pkg::S_PUSH_RD;
                        bmhpq_pkg::ACT_POP:
                        begin
                            if (count_reg == '0 || count_reg == CW'(1))
                                state_next = bmhpq_pkg::S_FIN_RD;
                            else
                                state_next = bmhpq_pkg::S_POP_RD;
                        end
                        default:
                            state_next = bmhpq_pkg::S_FIN_RD;
                    endcase
                end
            end
            bmhpq_pkg::S_PUSH_RD:
                state_next = (pos_reg == '0) ? bmhpq_pkg::S_FIN_RD : bmhpq_pkg::S_PUSH_CMP;
            bmhpq_pkg::S_PUSH_CMP:
                state_next = cmp_lt ? bmhpq_pkg::S_PUSH_RD : bmhpq_pkg::S_FIN_RD;
            bmhpq_pkg::S_POP_RD:
                state_next = bmhpq_pkg::S_POP_CAP;
            bmhpq_pkg::S_POP_CAP:
                state_next = bmhpq_pkg::S_DN_RDL;
            bmhpq_pkg::S_DN_RDL:
                state_next = (left_x >= count_x) ? bmhpq_pkg::S_FIN_RD : bmhpq_pkg::S_DN_RDR;
            bmhpq_pkg::S_DN_RDR:
                state_next = (right_x < count_x) ? bmhpq_pkg::S_DN_SEL : bmhpq_pkg::S_DN_DEC;
            bmhpq_pkg::S_DN_SEL:
                state_next = bmhpq_pkg::S_DN_DEC;
            bmhpq_pkg::S_DN_DEC:
                state_next = cmp_lt ? bmhpq_pkg::S_FIN_RD : bmhpq_pkg::S_DN_RDL;
            bmhpq_pkg::S_FIN_RD:
                state_next = (count_reg == '0) ? bmhpq_pkg::S_OUT : bmhpq_pkg::S_FIN_CAP;
            bmhpq_pkg::S_FIN_CAP:
                state_next = bmhpq_pkg::S_OUT;
            bmhpq_pkg::S_OUT:
                state_next = m_axis_tready ? bmhpq_pkg::S_IDLE : bmhpq_pkg::S_OUT;
            default:
                state_next = bmhpq_pkg::S_IDLE;
        endcase
    end

    // datapath, store port and comparator operands
    always_comb
    begin
        count_next    = count_reg;
        pos_next      = pos_reg;
        big_idx_next  = big_idx_reg;
        item_val_next = item_val_reg;
        item_pri_next = item_pri_reg;
        big_val_next  = big_val_reg;
        big_pri_next  = big_pri_reg;
        res_val_next  = res_val_reg;
        res_pri_next  = res_pri_reg;
        status_next   = status_reg;
        mem_en        = 1'b0;
        mem_we        = 1'b0;
        mem_addr      = '0;
        mem_wdata     = {item_pri_reg, item_val_reg};
        cmp_a         = big_pri_reg;
        cmp_b         = item_pri_reg;
        case (state_reg)
            bmhpq_pkg::S_IDLE:
            begin
                if (req_fire)
                begin
                    status_next   = bmhpq_pkg::ST_OK;
                    item_val_next = s_axis_tdata[DATA_WIDTH-1:0];
                    item_pri_next = s_axis_tdata[EW-1:DATA_WIDTH];
                    case (s_axis_tuser)
                        bmhpq_pkg::ACT_PUSH:
                        begin
                            if (full)
                            begin
                                status_next = bmhpq_pkg::ST_FULL;
                            end
                            else
                            begin
                                pos_next   = count_reg[AW-1:0];
                                count_next = count_reg + CW'(1);
                            end
                        end
                        bmhpq_pkg::ACT_POP:
                        begin
                            if (count_reg == '0)
                                status_next = bmhpq_pkg::ST_EMPTY;
                            else if (count_reg == CW'(1))
                                count_next = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            bmhpq_pkg::S_PUSH_RD:
            begin
                mem_en = 1'b1;
                if (pos_reg == '0)
                begin
                    mem_we = 1'b1;
                end
                else
                begin
                    mem_addr = parent;
                end
            end
            bmhpq_pkg::S_PUSH_CMP:
            begin
                cmp_a    = rd_pri;
                cmp_b    = item_pri_reg;
                mem_en   = 1'b1;
                mem_we   = 1'b1;
                mem_addr = pos_reg;
                if (cmp_lt)
                begin
                    mem_wdata = mem_rdata;
                    pos_next  = parent;
                end
            end
            bmhpq_pkg::S_POP_RD:
            begin
                mem_en   = 1'b1;
                mem_addr = last[AW-1:0];
            end
            bmhpq_pkg::S_POP_CAP:
            begin
                item_val_next = rd_val;
                item_pri_next = rd_pri;
                count_next    = last;
                pos_next      = '0;
            end
            bmhpq_pkg::S_DN_RDL:
            begin
                mem_en = 1'b1;
                if (left_x >= count_x)
                begin
                    mem_we   = 1'b1;
                    mem_addr = pos_reg;
                end
                else
                begin
                    mem_addr = left_x[AW-1:0];
                end
            end
            bmhpq_pkg::S_DN_RDR:
            begin
                big_val_next = rd_val;
                big_pri_next = rd_pri;
                big_idx_next = left_x[AW-1:0];
                if (right_x < count_x)
                begin
                    mem_en   = 1'b1;
                    mem_addr = right_x[AW-1:0];
                end
            end
            bmhpq_pkg::S_DN_SEL:
            begin
                cmp_a = big_pri_reg;
                cmp_b = rd_pri;
                if (cmp_lt)
                begin
                    big_val_next = rd_val;
                    big_pri_next = rd_pri;
                    big_idx_next = right_x[AW-1:0];
                end
            end
            bmhpq_pkg::S_DN_DEC:
            begin
                // swap while item priority is no greater than the bigger child
                cmp_a    = big_pri_reg;
                cmp_b    = item_pri_reg;
                mem_en   = 1'b1;
                mem_we   = 1'b1;
                mem_addr = pos_reg;
                if (!cmp_lt)
                begin
                    mem_wdata = {big_pri_reg, big_val_reg};
                    pos_next  = big_idx_reg;
                end
            end
            bmhpq_pkg::S_FIN_RD:
            begin
                if (count_reg == '0)
                begin
                    res_val_next = '0;
                    res_pri_next = '0;
                end
                else
                begin
                    mem_en = 1'b1;
                end
            end
            bmhpq_pkg::S_FIN_CAP:
            begin
                res_val_next = rd_val;
                res_pri_next = rd_pri;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bmhpq_pkg::S_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg      <= pos_next;
        big_idx_reg  <= big_idx_next;
        item_val_reg <= item_val_next;
        item_pri_reg <= item_pri_next;
        big_val_reg  <= big_val_next;
        big_pri_reg  <= big_pri_next;
        res_val_reg  <= res_val_next;
        res_pri_reg  <= res_pri_next;
        status_reg   <= status_next;
    end

    assign s_axis_tready = (state_reg == bmhpq_pkg::S_IDLE);
    assign m_axis_tvalid = (state_reg == bmhpq_pkg::S_OUT);
    assign m_axis_tdata  = OW'({count_reg, res_pri_reg, res_val_reg});
    assign m_axis_tuser  = {status_reg, (count_reg == '0)};

endmodule

// File: sv/bmhpq_chk.sv
// Port-level assertion checker for the priority queue, bound to the top level.
module bmhpq_chk #(
    parameter int DEPTH          = 64,
    parameter int DATA_WIDTH     = 32,
    parameter int PRIORITY_WIDTH = 16
) (
    input logic clk,
    input logic rst_n,
    input logic s_axis_tvalid,
    input logic s_axis_tready,
    input logic m_axis_tvalid,
    input logic m_axis_tready,
    input logic [((DATA_WIDTH+PRIORITY_WIDTH+$clog2(DEPTH+1)+7)/8)*8-1:0] m_axis_tdata,
    input logic [bmhpq_pkg::OUT_USER_W-1:0] m_axis_tuser
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int CL = DATA_WIDTH + PRIORITY_WIDTH;

    logic [CW-1:0] cnt;
    assign cnt = m_axis_tdata[CL+CW-1:CL];

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
        && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("ready right after accepting a request");

    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(m_axis_tvalid && s_axis_tready))
        else $error("ready while a result is pending");

    a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> cnt <= CW'(DEPTH))
        else $error("count beyond capacity");

    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tuser[0] == (cnt == '0))
        && (cnt != '0 || m_axis_tdata[CL-1:0] == '0))
        else $error("empty flag or front entry inconsistent with count");

endmodule

bind binary_max_heap_priority_queue_unit bmhpq_chk #(
    .DEPTH          (DEPTH),
    .DATA_WIDTH     (DATA_WIDTH),
    .PRIORITY_WIDTH (PRIORITY_WIDTH)
) u_bmhpq_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

// File: dv/binary_max_heap_priority_queue_unit_tb.sv
// Self-checking testbench for the binary max-heap priority queue: directed and random requests.
module binary_max_heap_priority_queue_unit_tb;

    localparam int HEAP_DEPTH = 64;
    localparam int VAL_W      = 32;
    localparam int PRI_W      = 16;
    localparam int CNT_W      = 7;
    localparam int IN_W       = ((VAL_W + PRI_W + 7) / 8) * 8;
    localparam int OUT_W      = ((VAL_W + PRI_W + CNT_W + 7) / 8) * 8;
    localparam logic [bmhpq_pkg::ACTION_W-1:0] ACT_SPARE = 2'd3;
    localparam int LONG_HOLD  = 400;

    typedef struct packed {
        logic [VAL_W-1:0]               value;
        logic [PRI_W-1:0]               prio;
        logic [CNT_W-1:0]               count;
        logic                           empty;
        logic [bmhpq_pkg::STATUS_W-1:0] status;
    } front_report_t;

    class heap_scoreboard;
        logic [VAL_W-1:0] slot_val[HEAP_DEPTH];
        logic [PRI_W-1:0] slot_pri[HEAP_DEPTH];
        int               fill;
        front_report_t    expected_fronts[$];
        int               errors;

        function new();
            fill   = 0;
            errors = 0;
        endfunction

        function int pending();
            return expected_fronts.size();
        endfunction

        function void swap_slots(int a, int b);
            logic [VAL_W-1:0] v;
            logic [PRI_W-1:0] p;
            v = slot_val[a];
            p = slot_pri[a];
            slot_val[a] = slot_val[b];
            slot_pri[a] = slot_pri[b];
            slot_val[b] = v;
            slot_pri[b] = p;
        endfunction

        function void sift_in(logic [VAL_W-1:0] v, logic [PRI_W-1:0] p);
            int pos;
            int up;
            pos = fill;
            slot_val[pos] = v;
            slot_pri[pos] = p;
            fill++;
            while (pos != 0) begin
                up = (pos - 1) / 2;
                if (slot_pri[up] >= slot_pri[pos])
                    break;
                swap_slots(up, pos);
                pos = up;
            end
        endfunction

        function void take_root();
            int pos;
            int lc;
            int big;
            if (fill == 1) begin
                fill = 0;
                return;
            end
            slot_val[0] = slot_val[fill-1];
            slot_pri[0] = slot_pri[fill-1];
            fill--;
            pos = 0;
            while (2 * pos + 1 < fill) begin
                lc  = 2 * pos + 1;
                big = lc;
                if (lc + 1 < fill && slot_pri[lc+1] > slot_pri[lc])
                    big = lc + 1;
                if (slot_pri[pos] > slot_pri[big])
                    break;
                swap_slots(pos, big);
                pos = big;
            end
        endfunction

        function void apply_request(logic [bmhpq_pkg::ACTION_W-1:0] act,
                                    logic [VAL_W-1:0] v, logic [PRI_W-1:0] p);
            front_report_t r;
            r.status = bmhpq_pkg::ST_OK;
            if (act == bmhpq_pkg::ACT_PUSH) begin
                if (fill >= HEAP_DEPTH)
                    r.status = bmhpq_pkg::ST_FULL;
                else
                    sift_in(v, p);
            end else if (act == bmhpq_pkg::ACT_POP) begin
                if (fill == 0)
                    r.status = bmhpq_pkg::ST_EMPTY;
                else
                    take_root();
            end
            r.value = (fill == 0) ? '0 : slot_val[0];
            r.prio  = (fill == 0) ? '0 : slot_pri[0];
            r.count = fill[CNT_W-1:0];
            r.empty = (fill == 0);
            expected_fronts.push_back(r);
        endfunction

        task report(string msg);
            $display("mismatch: %s", msg);
            errors++;
        endtask

        task check_result(logic [OUT_W-1:0] td, logic [bmhpq_pkg::OUT_USER_W-1:0] tu);
            front_report_t e;
            logic [VAL_W-1:0]               got_val;
            logic [PRI_W-1:0]               got_pri;
            logic [CNT_W-1:0]               got_cnt;
            logic [bmhpq_pkg::STATUS_W-1:0] got_st;
            got_val = td[VAL_W-1:0];
            got_pri = td[VAL_W+PRI_W-1:VAL_W];
            got_cnt = td[VAL_W+PRI_W+CNT_W-1:VAL_W+PRI_W];
            got_st  = tu[bmhpq_pkg::STATUS_W:1];
            if (expected_fronts.size() == 0) begin
                report($sformatf("unexpected result tdata=%h tuser=%h", td, tu));
                return;
            end
            e = expected_fronts.pop_front();
            if (got_val !== e.value)
                report($sformatf("front_value %h, want %h", got_val, e.value));
            if (got_pri !== e.prio)
                report($sformatf("front_priority %h, want %h", got_pri, e.prio));
            if (got_cnt !== e.count)
                report($sformatf("count %0d, want %0d", got_cnt, e.count));
            if (tu[0] !== e.empty)
                report($sformatf("is_empty %b, want %b", tu[0], e.empty));
            if (got_st !== e.status)
                report($sformatf("status %0d, want %0d", got_st, e.status));
        endtask
    endclass

    logic                             clk;
    logic                             rst_n;
    logic                             s_axis_tvalid;
    logic                             s_axis_tready;
    logic [IN_W-1:0]                  s_axis_tdata;
    logic [bmhpq_pkg::ACTION_W-1:0]   s_axis_tuser;
    logic                             m_axis_tvalid;
    logic                             m_axis_tready;
    logic [OUT_W-1:0]                 m_axis_tdata;
    logic [bmhpq_pkg::OUT_USER_W-1:0] m_axis_tuser;

    heap_scoreboard sb;
    bit             idle_on;
    bit             hold_now;
    bit             drain_now;

    binary_max_heap_priority_queue_unit #(
        .DEPTH(HEAP_DEPTH),
        .DATA_WIDTH(VAL_W),
        .PRIORITY_WIDTH(PRI_W)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tuser(m_axis_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #1000000;
        $display("Regression FAIL");
        $finish;
    end

    // tvalid stays high between back-to-back requests
    task automatic send_request(logic [bmhpq_pkg::ACTION_W-1:0] act, logic [VAL_W-1:0] v,
                                logic [PRI_W-1:0] p);
        int gap;
        gap = idle_on ? $urandom_range(0, 12) : 0;
        if (gap > 0 || drain_now) begin
            s_axis_tvalid <= 1'b0;
            if (drain_now) begin
                while (sb.pending() != 0)
                    @(posedge clk);
                drain_now = 1'b0;
            end
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= act;
        s_axis_tdata  <= {p, v};
        do
            @(posedge clk);
        while (!s_axis_tready);
        sb.apply_request(act, v, p);
    endtask

    initial
    begin
        bit rdy;
        int stall;
        rdy = 1'b0;
        m_axis_tready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever begin
            stall = idle_on ? $urandom_range(0, 12) : 0;
            if (hold_now) begin
                stall    = LONG_HOLD;
                hold_now = 1'b0;
            end
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
                rdy = 1'b0;
            end
            if (!rdy) begin
                m_axis_tready <= 1'b1;
                rdy = 1'b1;
            end
            do
                @(posedge clk);
            while (!m_axis_tvalid);
            sb.check_result(m_axis_tdata, m_axis_tuser);
        end
    end

    initial
    begin
        int phase_len;
        int push_pct;
        int pop_pct;
        int narrow;
        int r;
        int sent;
        logic [bmhpq_pkg::ACTION_W-1:0] act;
        logic [PRI_W-1:0]               p;

        sb            = new();
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = bmhpq_pkg::ACT_QUERY;
        idle_on       = 1'b1;
        hold_now      = 1'b0;
        drain_now     = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty heap corner cases
        send_request(bmhpq_pkg::ACT_QUERY, 32'hFFFF_FFFF, 16'hFFFF);
        send_request(bmhpq_pkg::ACT_POP, 32'h0, 16'h0);
        send_request(ACT_SPARE, 32'hDEAD_BEEF, 16'h1234);
        send_request(bmhpq_pkg::ACT_PUSH, 32'h0, 16'h0);
        send_request(bmhpq_pkg::ACT_PUSH, 32'hFFFF_FFFF, 16'hFFFF);
        send_request(bmhpq_pkg::ACT_PUSH, 32'h5555_AAAA, 16'h8000);
        // equal priorities: push stops below equal parent
        send_request(bmhpq_pkg::ACT_PUSH, 32'hAAAA_5555, 16'hFFFF);
        send_request(bmhpq_pkg::ACT_PUSH, 32'h0000_0007, 16'h0007);
        send_request(bmhpq_pkg::ACT_PUSH, 32'h0000_0008, 16'h0007);
        send_request(bmhpq_pkg::ACT_PUSH, 32'h0000_0009, 16'h0007);
        send_request(ACT_SPARE, 32'h0, 16'h0);
        send_request(bmhpq_pkg::ACT_QUERY, 32'h0, 16'h0);
        repeat (8)
            send_request(bmhpq_pkg::ACT_POP, $urandom(), PRI_W'($urandom_range(0, 65535)));
        send_request(bmhpq_pkg::ACT_POP, 32'h0, 16'h0);
        send_request(bmhpq_pkg::ACT_QUERY, 32'h0, 16'h0);

        // fill past capacity, then drain past empty
        for (int i = 0; i < HEAP_DEPTH + 4; i++)
            send_request(bmhpq_pkg::ACT_PUSH, $urandom(), PRI_W'($urandom_range(0, 65535)));
        for (int i = 0; i < HEAP_DEPTH + 2; i++)
            send_request(bmhpq_pkg::ACT_POP, $urandom(), PRI_W'($urandom_range(0, 65535)));

        sent = 0;
        while (sent < 1650) begin
            phase_len = $urandom_range(20, 120);
            r = $urandom_range(0, 3);
            push_pct = (r == 0) ? 85 : (r == 1) ? 15 : 45;
            pop_pct  = (r == 0) ? 10 : (r == 1) ? 75 : 45;
            narrow   = $urandom_range(0, 2);
            idle_on  = ($urandom_range(0, 3) != 0);
            for (int i = 0; i < phase_len; i++) begin
                if (sent == 300)
                    hold_now = 1'b1;
                if (sent == 700)
                    drain_now = 1'b1;
                r = $urandom_range(0, 99);
                if (r < push_pct)
                    act = bmhpq_pkg::ACT_PUSH;
                else if (r < push_pct + pop_pct)
                    act = bmhpq_pkg::ACT_POP;
                else
                    act = ($urandom_range(0, 3) == 0) ? ACT_SPARE : bmhpq_pkg::ACT_QUERY;
                if (narrow == 0)
                    p = PRI_W'($urandom_range(0, 7));
                else if (narrow == 1 && $urandom_range(0, 7) == 0)
                    p = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
                else
                    p = PRI_W'($urandom_range(0, 65535));
                send_request(act, $urandom(), p);
                sent++;
            end
        end

        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// File: filelist.f
sv/bmhpq_pkg.sv
sv/bmhpq_mem.sv
sv/bmhpq_cmp.sv
sv/binary_max_heap_priority_queue_unit.sv
sv/bmhpq_chk.sv
dv/binary_max_heap_priority_queue_unit_tb.sv
